FILE: rtl/coospmv_pkg.sv
package coospmv_pkg;

	// field widths
	localparam int DIM_W      = 7;
	localparam int VAL_W      = 32;
	localparam int FRAC_W     = 16;
	localparam int ACT_W      = 2;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;

	// action codes carried on s_tuser
	localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ACC  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_EMIT = 2'd2;

	// status codes carried on m_tuser
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISMATCH = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_IDX  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VLEN = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	typedef logic signed [VAL_W-1:0] q16_t;

endpackage

FILE: rtl/coospmv_mac.sv
module coospmv_mac (
	input  logic                clk,
	input  logic                mul_en,
	input  coospmv_pkg::q16_t   mat_val,
	input  coospmv_pkg::q16_t   vec_val,
	input  coospmv_pkg::q16_t   acc_val,
	output coospmv_pkg::q16_t   sum
);
	import coospmv_pkg::*;

	localparam int PROD_W = 2 * VAL_W;
	localparam int SH_W   = PROD_W - FRAC_W;
	localparam int SUM_W  = SH_W + 1;

	localparam logic signed [SUM_W-1:0] SAT_MAX =
		{{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_MIN =
		{{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SH_W-1:0]   prod_sh;
	logic signed [SUM_W-1:0]  sum_wide;

	// full-precision product, registered before the add
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= mat_val * vec_val;
		end
	end

	// arithmetic shift by the fraction width, then saturating add
	always_comb begin
		prod_sh  = prod_s1[PROD_W-1:FRAC_W];
		sum_wide = {{(SUM_W-VAL_W){acc_val[VAL_W-1]}}, acc_val}
			+ {prod_sh[SH_W-1], prod_sh};
		if (sum_wide > SAT_MAX) begin
			sum = SAT_MAX[VAL_W-1:0];
		end else if (sum_wide < SAT_MIN) begin
			sum = SAT_MIN[VAL_W-1:0];
		end else begin
			sum = sum_wide[VAL_W-1:0];
		end
	end

endmodule

FILE: rtl/coo_sparse_matrix_vector_multiply.sv
// Sparse matrix times dense vector, coordinate form, signed Q16.16.
// Input stream: s_tuser carries the action (load vector element, accumulate
// one nonzero, emit); s_tdata carries row_index, col_index and value.
// Output stream: m_tdata carries out_row and out_value, m_tlast marks the
// final row of an emission, m_tuser carries the status code.
// Configuration: cfg_we/cfg_index/cfg_wdata write row_count, col_count and
// vector_length; write only while the block is idle.
// A vector load is written while idle. An accumulate reads both memories,
// then does the registered 32x32 multiply, then the saturating add and
// write back; no new request is taken until that write back is done. An
// emit request walks the rows, each read from the accumulator memory and
// then loaded into the output register, through the single registered read port.
// A dimension mismatch gives one error result instead.
// Reset clears the per-entry valid bits of both memories at once, so both
// stores read as zero right after reset with no clearing pass.
// When the receiver stalls, the result holds in the output register and the
// emission walk pauses; a new request is taken once the last row is loaded.
module coo_sparse_matrix_vector_multiply #(
	parameter int MAX_DIM = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input request
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// row_index[6:0], col_index[13:7], value[45:14], zero fill [47:46]
	input  logic [coospmv_pkg::IN_DATA_W-1:0]    s_tdata,
	// action[1:0]
	input  logic [coospmv_pkg::ACT_W-1:0]        s_tuser,
	// result
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// out_row[6:0], out_value[38:7], zero fill [39]
	output logic [coospmv_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                                 m_tlast,
	// status[1:0]
	output logic [coospmv_pkg::STAT_W-1:0]       m_tuser,
	// configuration write
	input  logic                                 cfg_we,
	input  logic [coospmv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [coospmv_pkg::DIM_W-1:0]        cfg_wdata
);
	import coospmv_pkg::*;

	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);
	localparam logic [DIM_W-1:0] ONE = DIM_W'(1);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_MUL      = 3'd1;
	localparam logic [2:0] S_ADD      = 3'd2;
	localparam logic [2:0] S_EMIT_RD  = 3'd3;
	localparam logic [2:0] S_EMIT_OUT = 3'd4;
	localparam logic [2:0] S_EMIT_ERR = 3'd5;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v < ONE) begin
			r = ONE;
		end else if (v > MAX_DIM_V) begin
			r = MAX_DIM_V;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// configuration
	logic [DIM_W-1:0] row_count_q, col_count_q, vec_len_q;
	logic [DIM_W-1:0] rows, cols, vlen;

	// control
	logic [2:0]    state_q;
	logic [AW-1:0] emit_cnt_q;
	logic [AW-1:0] acc_addr_q;
	logic          bad_q;
	logic          emit_done;

	// input fields
	logic [ACT_W-1:0] in_action;
	logic [DIM_W-1:0] in_row, in_col, row_dec, col_dec;
	q16_t             in_value;
	logic             accept;
	logic             row_ok, col_ok_acc, col_ok_vec;
	logic [AW-1:0]    row_addr, col_addr;
	logic             vec_we, acc_lookup;

	// memories and their registered read ports
	q16_t             vec_mem [MAX_DIM];
	q16_t             acc_mem [MAX_DIM];
	logic [MAX_DIM-1:0] vec_vld_q, acc_vld_q;
	q16_t             vec_rd_q, acc_rd_q;
	logic             vec_rd_vld_q, acc_rd_vld_q;
	logic             acc_rd_en, acc_we;
	logic [AW-1:0]    acc_rd_addr;
	q16_t             mat_val_q;
	q16_t             vec_eff, acc_eff, mac_sum;

	// output register
	logic             out_vld_q, out_last_q, out_free, out_load;
	logic [DIM_W-1:0] out_row_q, out_row_d;
	q16_t             out_value_q, out_value_d;
	logic [STAT_W-1:0] out_stat_q, out_stat_d;
	logic             out_last_d, last_row;

	assign rows = clamp_dim(row_count_q);
	assign cols = clamp_dim(col_count_q);
	assign vlen = clamp_dim(vec_len_q);

	assign in_action = s_tuser;
	assign in_row    = s_tdata[DIM_W-1:0];
	assign in_col    = s_tdata[2*DIM_W-1:DIM_W];
	assign in_value  = s_tdata[2*DIM_W+VAL_W-1:2*DIM_W];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign row_dec    = in_row - ONE;
	assign col_dec    = in_col - ONE;
	assign row_addr   = row_dec[AW-1:0];
	assign col_addr   = col_dec[AW-1:0];
	assign row_ok     = (in_row >= ONE) && (in_row <= rows);
	assign col_ok_acc = (in_col >= ONE) && (in_col <= cols);
	assign col_ok_vec = (in_col >= ONE) && (in_col <= vlen);

	assign vec_we     = accept && (in_action == ACT_LOAD) && col_ok_vec;
	assign acc_lookup = accept && (in_action == ACT_ACC) && row_ok && col_ok_acc;

	assign acc_rd_en   = acc_lookup || (state_q == S_EMIT_RD);
	assign acc_rd_addr = (state_q == S_EMIT_RD) ? emit_cnt_q : row_addr;
	assign acc_we      = (state_q == S_ADD);

	// configuration writes; other indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= DIM_RESET;
			col_count_q <= DIM_RESET;
			vec_len_q   <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS: row_count_q <= cfg_wdata;
				REG_COLS: col_count_q <= cfg_wdata;
				REG_VLEN: vec_len_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// vector store: write on load, read on accumulate
	always_ff @(posedge clk) begin
		if (vec_we) begin
			vec_mem[col_addr] <= in_value;
		end
		if (acc_lookup) begin
			vec_rd_q     <= vec_mem[col_addr];
			vec_rd_vld_q <= vec_vld_q[col_addr];
		end
	end

	// accumulator store: read on accumulate or emission walk, write back
	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_addr_q] <= mac_sum;
		end
		if (acc_rd_en) begin
			acc_rd_q     <= acc_mem[acc_rd_addr];
			acc_rd_vld_q <= acc_vld_q[acc_rd_addr];
		end
		if (acc_lookup) begin
			mat_val_q <= in_value;
		end
	end

	// valid bits stand in for clearing the stores; an invalid entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_vld_q <= '0;
			acc_vld_q <= '0;
		end else begin
			if (vec_we) begin
				vec_vld_q[col_addr] <= 1'b1;
			end
			if (emit_done) begin
				acc_vld_q <= '0;
			end else if (acc_we) begin
				acc_vld_q[acc_addr_q] <= 1'b1;
			end
		end
	end

	assign vec_eff = vec_rd_vld_q ? vec_rd_q : '0;
	assign acc_eff = acc_rd_vld_q ? acc_rd_q : '0;

	coospmv_mac u_mac (
		.clk     (clk),
		.mul_en  (state_q == S_MUL),
		.mat_val (mat_val_q),
		.vec_val (vec_eff),
		.acc_val (acc_eff),
		.sum     (mac_sum)
	);

	assign out_free = !out_vld_q || m_tready;
	assign last_row = ({{(DIM_W-AW){1'b0}}, emit_cnt_q} == (rows - ONE));

	always_comb begin
		out_load    = 1'b0;
		emit_done   = 1'b0;
		out_row_d   = {{(DIM_W-AW){1'b0}}, emit_cnt_q} + ONE;
		out_value_d = acc_eff;
		out_last_d  = last_row;
		out_stat_d  = bad_q ? STAT_BAD_IDX : STAT_OK;
		case (state_q)
			S_EMIT_OUT: begin
				out_load  = out_free;
				emit_done = out_free && last_row;
			end
			S_EMIT_ERR: begin
				out_load    = out_free;
				emit_done   = out_free;
				out_row_d   = '0;
				out_value_d = '0;
				out_last_d  = 1'b1;
				out_stat_d  = STAT_MISMATCH;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			emit_cnt_q <= '0;
			acc_addr_q <= '0;
			bad_q      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_action)
							ACT_LOAD: begin
								if (!col_ok_vec) begin
									bad_q <= 1'b1;
								end
							end
							ACT_ACC: begin
								if (row_ok && col_ok_acc) begin
									acc_addr_q <= row_addr;
									state_q    <= S_MUL;
								end else begin
									bad_q <= 1'b1;
								end
							end
							ACT_EMIT: begin
								emit_cnt_q <= '0;
								state_q    <= (cols != vlen) ? S_EMIT_ERR : S_EMIT_RD;
							end
							default: ;
						endcase
					end
				end
				S_MUL:     state_q <= S_ADD;
				S_ADD:     state_q <= S_IDLE;
				S_EMIT_RD: state_q <= S_EMIT_OUT;
				S_EMIT_OUT: begin
					if (out_free) begin
						if (last_row) begin
							bad_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							emit_cnt_q <= emit_cnt_q + AW'(1);
							state_q    <= S_EMIT_RD;
						end
					end
				end
				S_EMIT_ERR: begin
					if (out_free) begin
						bad_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q   <= out_row_d;
			out_value_q <= out_value_d;
			out_last_q  <= out_last_d;
			out_stat_q  <= out_stat_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_value_q, out_row_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_stat_q;

endmodule

FILE: rtl/coospmv_checker.sv
module coospmv_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [coospmv_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                               m_tlast,
	input logic [coospmv_pkg::STAT_W-1:0]     m_tuser
);
	import coospmv_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
			&& $stable(m_tlast) && $stable(m_tuser))
		else $error("result changed while stalled");

	// error result is a lone zero row marked last
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_MISMATCH) |-> m_tlast && (m_tdata == '0))
		else $error("malformed mismatch result");

	// normal rows are numbered from one
	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_MISMATCH) |-> (m_tdata[DIM_W-1:0] != '0))
		else $error("row number zero on normal result");

	// status stays the same within one emission
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> $stable(m_tuser))
		else $error("status changed within an emission");

endmodule

bind coo_sparse_matrix_vector_multiply coospmv_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

FILE: tb/tb_coo_sparse_matrix_vector_multiply.sv
module tb_coo_sparse_matrix_vector_multiply;
	timeunit 1ns;
	timeprecision 1ps;

	import coospmv_pkg::*;

	localparam int MAX_DIM         = 64;
	// long receiver hold-off used to back the block up into its input
	localparam int STALL_LEN       = 300;
	// accumulate requests still multiply and write back after they are taken,
	// so give the block a margin after the last result before touching the registers
	localparam int SETTLE_CYCLES   = 12;
	// longest legal quiet stretch is the long hold-off plus random stalls
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int LOUD_MISMATCHES = 10;
	// the unused action: the block must swallow it without a result
	localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

	typedef struct {
		logic [ACT_W-1:0] action;
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
		q16_t             value;
	} coo_req_t;

	typedef struct {
		logic [DIM_W-1:0]  row;
		q16_t              value;
		logic              last;
		logic [STAT_W-1:0] status;
	} row_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [ACT_W-1:0]      s_tuser = ACT_LOAD;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic [STAT_W-1:0]     m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_ROWS;
	logic [DIM_W-1:0]      cfg_wdata = DIM_RESET;

	// requests waiting to be offered, and rows the block still owes us
	coo_req_t    pending_requests[$];
	row_result_t due_rows[$];
	coo_req_t    offered_req;
	row_result_t got_row;
	row_result_t want_row;

	// mirror of the block: dense vector, per-row sums, sticky bad-index flag
	q16_t             vec_mirror[MAX_DIM] = '{default: '0};
	q16_t             acc_mirror[MAX_DIM] = '{default: '0};
	bit               bad_seen = 1'b0;
	logic [DIM_W-1:0] rows_reg = DIM_RESET;
	logic [DIM_W-1:0] cols_reg = DIM_RESET;
	logic [DIM_W-1:0] vlen_reg = DIM_RESET;

	int req_gap_pct = 0;
	int rsp_stall_pct = 0;
	bit sink_stall_kick = 1'b0;
	int sink_stall_left;
	int quiet_cycles = 0;
	int mismatches = 0;

	coo_sparse_matrix_vector_multiply #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Registers act as their value clamped to 1..MAX_DIM.
	function automatic int clamp_dim(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	// Advance the mirror by one accepted request and queue the rows it owes.
	task automatic apply_request(input coo_req_t rq);
		int          rows;
		int          cols;
		int          vlen;
		longint      prod;
		longint      sum;
		row_result_t res;
		rows = clamp_dim(rows_reg);
		cols = clamp_dim(cols_reg);
		vlen = clamp_dim(vlen_reg);
		case (rq.action)
			ACT_LOAD: begin
				if (rq.col < 1 || rq.col > vlen)
					bad_seen = 1'b1;
				else
					vec_mirror[rq.col - 1] = rq.value;
			end
			ACT_ACC: begin
				if (rq.row < 1 || rq.row > rows || rq.col < 1 || rq.col > cols) begin
					bad_seen = 1'b1;
				end else begin
					// exact 64-bit product, arithmetic shift rounds toward minus infinity
					prod = (longint'(rq.value) * longint'(vec_mirror[rq.col - 1])) >>> FRAC_W;
					sum = longint'(acc_mirror[rq.row - 1]) + prod;
					if (sum > longint'(32'sh7FFF_FFFF))
						sum = longint'(32'sh7FFF_FFFF);
					if (sum < -longint'(64'sh8000_0000))
						sum = -longint'(64'sh8000_0000);
					acc_mirror[rq.row - 1] = q16_t'(sum);
				end
			end
			ACT_EMIT: begin
				if (cols != vlen) begin
					// dimension mismatch: one error row instead of the walk
					res.row = '0;
					res.value = '0;
					res.last = 1'b1;
					res.status = STAT_MISMATCH;
					due_rows.push_back(res);
				end else begin
					for (int r = 0; r < rows; r++) begin
						res.row = DIM_W'(r + 1);
						res.value = acc_mirror[r];
						res.last = (r == rows - 1);
						res.status = bad_seen ? STAT_BAD_IDX : STAT_OK;
						due_rows.push_back(res);
					end
				end
				// emission clears the sums and the flag either way
				foreach (acc_mirror[i])
					acc_mirror[i] = '0;
				bad_seen = 1'b0;
			end
			default: ;
		endcase
	endtask

	// Driver: hold the request until taken, then advance to the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= ACT_LOAD;
		end else begin
			if (s_tvalid && s_tready)
				apply_request(offered_req);
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
					offered_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, offered_req.value, offered_req.col, offered_req.row};
					s_tuser <= offered_req.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_mismatch(input string msg);
		if (mismatches < LOUD_MISMATCHES)
			$display("%s", msg);
		mismatches++;
	endtask

	// Monitor: check every accepted row against the oldest one owed, and
	// drive m_tready with random stalls plus the long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_row.row = m_tdata[DIM_W-1:0];
				got_row.value = m_tdata[DIM_W+VAL_W-1:DIM_W];
				got_row.last = m_tlast;
				got_row.status = m_tuser;
				if (due_rows.size() == 0) begin
					flag_mismatch($sformatf("unexpected row: row %0d value %h last %b status %0d",
						got_row.row, got_row.value, got_row.last, got_row.status));
				end else begin
					want_row = due_rows.pop_front();
					if (got_row.row !== want_row.row || got_row.value !== want_row.value ||
						got_row.last !== want_row.last || got_row.status !== want_row.status)
						flag_mismatch($sformatf({"row mismatch: expected row %0d value %h last %b ",
							"status %0d, got row %0d value %h last %b status %0d"},
							want_row.row, want_row.value, want_row.last, want_row.status,
							got_row.row, got_row.value, got_row.last, got_row.status));
				end
			end
			if (sink_stall_kick)
				sink_stall_left <= STALL_LEN;
			else if (sink_stall_left != 0)
				sink_stall_left <= sink_stall_left - 1;
			m_tready <= !sink_stall_kick && sink_stall_left <= 1 &&
				$urandom_range(99) >= rsp_stall_pct;
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("FAIL coo_sparse_matrix_vector_multiply");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic push_req(input logic [ACT_W-1:0] action, input logic [DIM_W-1:0] row,
		input logic [DIM_W-1:0] col, input q16_t value);
		coo_req_t rq;
		rq.action = action;
		rq.row = row;
		rq.col = col;
		rq.value = value;
		pending_requests.push_back(rq);
	endtask

	// Mix of small fractions, moderate values, full-range noise and the corners.
	function automatic q16_t rand_q16();
		case ($urandom_range(3))
			0: return q16_t'(int'($urandom_range(1048575)) - 524288);
			1: return q16_t'($urandom);
			2: begin
				case ($urandom_range(3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sh0000_0000;
					default: return 32'shFFFF_FFFF;
				endcase
			end
			default: return q16_t'(int'($urandom_range(33554431)) - 16777216);
		endcase
	endfunction

	// Index outside 1..lim: zero or anything above the limit.
	function automatic logic [DIM_W-1:0] off_range(input int lim);
		if ($urandom_range(1))
			return '0;
		return DIM_W'($urandom_range(127, lim + 1));
	endfunction

	// Well-formed traffic: prime part of the vector, then mostly loads and
	// in-range nonzeros with emits mixed in, a little noise, closing emit.
	task automatic queue_random(input int n);
		int rows;
		int cols;
		int vlen;
		int pick;
		rows = clamp_dim(rows_reg);
		cols = clamp_dim(cols_reg);
		vlen = clamp_dim(vlen_reg);
		for (int k = 1; k <= 6 && k <= vlen; k++)
			push_req(ACT_LOAD, DIM_W'($urandom), DIM_W'(k), rand_q16());
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 28)
				push_req(ACT_LOAD, DIM_W'($urandom), DIM_W'($urandom_range(vlen, 1)), rand_q16());
			else if (pick < 80)
				push_req(ACT_ACC, DIM_W'($urandom_range(rows, 1)),
					DIM_W'($urandom_range(cols, 1)), rand_q16());
			else if (pick < 89)
				push_req(ACT_EMIT, DIM_W'($urandom), DIM_W'($urandom), rand_q16());
			else if (pick < 93)
				push_req(ACT_NOP, DIM_W'($urandom), DIM_W'($urandom), rand_q16());
			else if (pick < 96)
				push_req(ACT_LOAD, DIM_W'($urandom), off_range(vlen), rand_q16());
			else if ($urandom_range(1))
				push_req(ACT_ACC, off_range(rows), DIM_W'($urandom_range(cols, 1)), rand_q16());
			else
				push_req(ACT_ACC, DIM_W'($urandom_range(rows, 1)), off_range(cols), rand_q16());
		end
		push_req(ACT_EMIT, DIM_W'($urandom), DIM_W'($urandom), rand_q16());
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ROWS: rows_reg = data;
			REG_COLS: cols_reg = data;
			default: vlen_reg = data;
		endcase
	endtask

	task automatic program_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
		input logic [DIM_W-1:0] vlen);
		write_reg(REG_ROWS, rows);
		write_reg(REG_COLS, cols);
		write_reg(REG_VLEN, vlen);
		@(negedge clk);
	endtask

	// Hold until every request is taken and every owed row has come back,
	// then give in-flight accumulates time to land.
	task automatic settle_idle();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || due_rows.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pass at reset dimensions (64 x 64, vector 64).
		req_gap_pct = 21;
		rsp_stall_pct = 55;
		push_req(ACT_LOAD, 7'd0, 7'd1, 32'sh7FFF_FFFF);
		push_req(ACT_LOAD, 7'd127, 7'd64, 32'sh8000_0000);
		push_req(ACT_LOAD, 7'd0, 7'd2, 32'sh0001_0000);
		push_req(ACT_LOAD, 7'd0, 7'd3, 32'shFFFF_FFFF);
		// vector positions out of range: drop and set the sticky flag
		push_req(ACT_LOAD, 7'd127, 7'd0, 32'sh1234_5678);
		push_req(ACT_LOAD, 7'd0, 7'd65, 32'sh1234_5678);
		push_req(ACT_LOAD, 7'd0, 7'd127, 32'shFFFF_FFFF);
		// saturate high, then stay saturated
		push_req(ACT_ACC, 7'd1, 7'd1, 32'sh7FFF_FFFF);
		push_req(ACT_ACC, 7'd1, 7'd1, 32'sh7FFF_FFFF);
		// saturate low, then swing back to the top
		push_req(ACT_ACC, 7'd64, 7'd64, 32'sh7FFF_FFFF);
		push_req(ACT_ACC, 7'd64, 7'd64, 32'sh8000_0000);
		// one times one, and the floor rounding of tiny products
		push_req(ACT_ACC, 7'd2, 7'd2, 32'sh0001_0000);
		push_req(ACT_ACC, 7'd3, 7'd2, 32'shFFFF_FFFF);
		push_req(ACT_ACC, 7'd3, 7'd3, 32'shFFFF_FFFF);
		// matrix indices out of range
		push_req(ACT_ACC, 7'd0, 7'd1, 32'sh0001_0000);
		push_req(ACT_ACC, 7'd65, 7'd1, 32'sh0001_0000);
		push_req(ACT_ACC, 7'd1, 7'd0, 32'sh0001_0000);
		push_req(ACT_ACC, 7'd127, 7'd127, 32'sh7FFF_FFFF);
		push_req(ACT_EMIT, 7'd0, 7'd0, 32'sh0000_0000);
		// unused action gives nothing
		push_req(ACT_NOP, 7'd127, 7'd127, 32'shFFFF_FFFF);
		push_req(ACT_ACC, 7'd5, 7'd4, 32'sh0003_8000);
		push_req(ACT_EMIT, 7'd127, 7'd127, 32'shFFFF_FFFF);
		settle_idle();

		// Smallest dimensions.
		program_dims(7'd1, 7'd1, 7'd1);
		queue_random(25);
		settle_idle();

		// Out-of-range register values: 0 acts as 1, 127 as the maximum.
		program_dims(7'd0, 7'd127, 7'd64);
		queue_random(20);
		settle_idle();

		// Swap who idles more; columns and vector disagree, so every emit errors.
		req_gap_pct = 55;
		rsp_stall_pct = 21;
		program_dims(7'd20, 7'd100, 7'd0);
		queue_random(15);
		settle_idle();

		program_dims(7'd8, 7'd8, 7'd8);
		queue_random(60);
		settle_idle();

		// No idling; hold the receiver off while requests keep coming so the
		// output stalls and backs up into the input.
		req_gap_pct = 0;
		rsp_stall_pct = 0;
		program_dims(7'd64, 7'd16, 7'd16);
		queue_random(55);
		sink_stall_kick = 1'b1;
		@(negedge clk);
		sink_stall_kick = 1'b0;
		settle_idle();

		program_dims(7'd13, 7'd33, 7'd33);
		queue_random(45);
		settle_idle();

		if (mismatches == 0)
			$display("PASS coo_sparse_matrix_vector_multiply");
		else
			$display("FAIL coo_sparse_matrix_vector_multiply");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/coospmv_pkg.sv
rtl/coospmv_mac.sv
rtl/coo_sparse_matrix_vector_multiply.sv
rtl/coospmv_checker.sv
tb/tb_coo_sparse_matrix_vector_multiply.sv
